FILE: sv/mrc_pkg.sv
// Shared types, constants and CRC helper for the Modbus RTU response checker.
package mrc_pkg;

   localparam int unsigned MAX_FRAME_BYTES_DEF = 256;
   localparam int unsigned FRAME_LEN_W         = 9;
   localparam int unsigned CRC_W               = 16;
   localparam int unsigned BYTE_W              = 8;

   localparam logic [BYTE_W-1:0] MIN_LEN_RESET = 8'd5;
   localparam logic [CRC_W-1:0]  CRC_INIT      = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY      = 16'hA001;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SHORT = 2'd1,
      ST_CRC   = 2'd2,
      ST_OVER  = 2'd3
   } frame_status_type;

   typedef enum logic {
      OP_DATA = 1'b0,
      OP_EOF  = 1'b1
   } opcode_type;

   // One accepted input word as seen by the frame core.
   typedef struct packed {
      logic              take;
      logic              opcode;
      logic [BYTE_W-1:0] rx_byte;
   } step_type;

   typedef struct packed {
      frame_status_type       frame_status;
      logic [FRAME_LEN_W-1:0] frame_length;
      logic [CRC_W-1:0]       trailer_crc;
      logic [CRC_W-1:0]       computed_crc;
   } result_type;

   // Modbus CRC-16, one byte folded in, LSB first.
   function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: sv/mrc_channels.sv
// Handshake channel interfaces: request words, response words, register writes.
interface mrc_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] rx_byte;
   modport source (output valid, output opcode, output rx_byte, input ready);
   modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface mrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] frame_status;
   logic [8:0] frame_length;
   logic [15:0] trailer_crc;
   logic [15:0] computed_crc;
   modport source (output valid, output frame_status, output frame_length,
                   output trailer_crc, output computed_crc, input ready);
   modport sink   (input valid, input frame_status, input frame_length,
                   input trailer_crc, input computed_crc, output ready);
endinterface

interface mrc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] min_frame_length;
   modport source (output valid, output min_frame_length, input ready);
   modport sink   (input valid, input min_frame_length, output ready);
endinterface

FILE: sv/mrc_frame_core.sv
// Frame state: byte count, two held bytes, running CRC, overflow flag and verdict.
module mrc_frame_core #(
   parameter int unsigned MAX_FRAME_BYTES = mrc_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mrc_pkg::step_type         step,
   input  logic [mrc_pkg::BYTE_W-1:0] min_len,
   output mrc_pkg::result_type       result
);

   localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
   localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [mrc_pkg::CRC_W-1:0] held_ff, held_in;
   logic [mrc_pkg::CRC_W-1:0] crc_ff, crc_in;
   logic                      ovf_ff, ovf_in;
   logic                      is_short;

   // too short: under two bytes, or under the programmed minimum
   assign is_short = (count_ff < CNT_TWO) ||
                     (mrc_pkg::FRAME_LEN_W'(count_ff) <
                      {{(mrc_pkg::FRAME_LEN_W-mrc_pkg::BYTE_W){1'b0}}, min_len});

   always_comb begin
      count_in = count_ff;
      held_in  = held_ff;
      crc_in   = crc_ff;
      ovf_in   = ovf_ff;

      result.frame_length = mrc_pkg::FRAME_LEN_W'(count_ff);
      result.trailer_crc  = held_ff;
      result.computed_crc = crc_ff;
      if (ovf_ff) begin
         result.frame_status = mrc_pkg::ST_OVER;
      end else if (is_short) begin
         result.frame_status = mrc_pkg::ST_SHORT;
      end else if (held_ff == crc_ff) begin
         result.frame_status = mrc_pkg::ST_OK;
      end else begin
         result.frame_status = mrc_pkg::ST_CRC;
      end

      if (step.take) begin
         if (step.opcode == mrc_pkg::OP_EOF) begin
            count_in = '0;
            held_in  = '0;
            crc_in   = mrc_pkg::CRC_INIT;
            ovf_in   = 1'b0;
         end else if (count_ff == CNT_MAX) begin
            ovf_in = 1'b1;
         end else begin
            // oldest held byte leaves the window and goes into the CRC
            if (count_ff >= CNT_TWO) begin
               crc_in = mrc_pkg::crc_fold(crc_ff, held_ff[7:0]);
            end
            held_in  = {step.rx_byte, held_ff[15:8]};
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         held_ff  <= '0;
         crc_ff   <= mrc_pkg::CRC_INIT;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         held_ff  <= held_in;
         crc_ff   <= crc_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

FILE: sv/modbus_rtu_response_checker.sv
// Top level of the Modbus RTU response checker: channels, register, result register.
//
//   channel  dir  payload                                         word moved when
//   req_if   in   opcode, rx_byte                                  valid & ready
//   rsp_if   out  frame_status, frame_length, trailer_crc, computed_crc  valid & ready
//   csr_if   in   min_frame_length                                 valid & ready
//
// One request word per clock while req_if is not stalled. Each word is folded into the frame
// state in the cycle it is accepted; an end-of-frame word loads the result
// register, shown on rsp_if the next cycle. A data word gives no response.
// req_if stalls only while a result waits in the result register and
// rsp_if.ready is low. Synchronous reset clears the frame and sets the
// minimum length to 5. csr_if is always ready.
module modbus_rtu_response_checker #(
   parameter int unsigned MAX_FRAME_BYTES = mrc_pkg::MAX_FRAME_BYTES_DEF
) (
   input logic          clock,
   input logic          reset,
   mrc_req_if.sink      req_if,
   mrc_rsp_if.source    rsp_if,
   mrc_csr_if.sink      csr_if
);

   logic [mrc_pkg::BYTE_W-1:0] min_len_ff, min_len_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   mrc_pkg::result_type        rsp_data_ff, rsp_data_in;
   mrc_pkg::step_type          step;
   mrc_pkg::result_type        frame_result;
   logic                       req_take;

   // Result slot is free, or is being emptied this cycle.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_take     = req_if.valid && req_if.ready;

   assign step.take    = req_take;
   assign step.opcode  = req_if.opcode;
   assign step.rx_byte = req_if.rx_byte;

   mrc_frame_core #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .min_len (min_len_ff),
      .result  (frame_result)
   );

   // register write port, never stalls
   assign csr_if.ready = 1'b1;
   assign min_len_in   = (csr_if.valid) ? csr_if.min_frame_length : min_len_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_take && (req_if.opcode == mrc_pkg::OP_EOF)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = frame_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff   <= mrc_pkg::MIN_LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_len_ff   <= min_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.frame_status = rsp_data_ff.frame_status;
   assign rsp_if.frame_length = rsp_data_ff.frame_length;
   assign rsp_if.trailer_crc  = rsp_data_ff.trailer_crc;
   assign rsp_if.computed_crc = rsp_data_ff.computed_crc;

   // end of frame always lands a result
   a_eof_result: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_if.opcode == mrc_pkg::OP_EOF) |=> rsp_valid_ff)
      else $error("end of frame produced no result");

   // data bytes never produce a result
   a_data_silent: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_if.opcode == mrc_pkg::OP_DATA) |=> !rsp_valid_ff)
      else $error("data byte produced a result");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.frame_length <=
                        mrc_pkg::FRAME_LEN_W'(MAX_FRAME_BYTES)))
      else $error("frame length above buffer size");

   a_over_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.frame_status == mrc_pkg::ST_OVER) |->
      (rsp_data_ff.frame_length == mrc_pkg::FRAME_LEN_W'(MAX_FRAME_BYTES)))
      else $error("overflow reported below buffer size");

   a_ok_crc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.frame_status == mrc_pkg::ST_OK) |->
      (rsp_data_ff.trailer_crc == rsp_data_ff.computed_crc))
      else $error("ok status with CRC mismatch");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the Modbus RTU response checker: CRC, length and status.
module tb_top;

   // Frame size limit of the block (parameter left at its default).
   localparam int unsigned FRAME_CAP   = mrc_pkg::MAX_FRAME_BYTES_DEF;
   // Cycles without any handshake before the run is declared hung.
   localparam int unsigned QUIET_LIMIT = 500;
   // Pause after the last response before a register write or the end of run.
   localparam int unsigned SETTLE      = 4;

   logic clock;
   logic reset;

   mrc_req_if req_ch ();
   mrc_rsp_if rsp_ch ();
   mrc_csr_if csr_ch ();

   modbus_rtu_response_checker dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // ---------------------------------------------------------------------------
   // Predictor state: a private copy of the frame checker.
   // ---------------------------------------------------------------------------
   logic [7:0]  min_len_reg;    // shadow of the minimum-length register
   logic [15:0] frame_crc;      // running CRC over all but the two newest bytes
   logic [15:0] frame_tail;     // [15:8] newest byte, [7:0] the one before
   logic [8:0]  frame_count;    // bytes taken in this frame, stops at FRAME_CAP
   logic        frame_overrun;  // a byte arrived with the frame already full

   mrc_pkg::result_type expected_frames[$];  // verdicts still owed by the block
   logic [7:0]          frame_buf[$];        // frame being built for sending

   int unsigned mismatches;
   int unsigned sent_words;
   int unsigned gap_pct;        // chance (percent) of a send gap before a word
   int unsigned stall_pct;      // chance (percent) of a response stall burst
   int unsigned quiet_cycles;

   // Modbus CRC-16, bit-serial: each data bit enters at the LSB side.
   function automatic logic [15:0] modbus_crc_byte(logic [15:0] crc, logic [7:0] d);
      logic [15:0] r;
      r = crc;
      for (int k = 0; k < 8; k++) begin
         if (r[0] ^ d[k]) begin
            r = {1'b0, r[15:1]} ^ mrc_pkg::CRC_POLY;
         end else begin
            r = {1'b0, r[15:1]};
         end
      end
      return r;
   endfunction

   function automatic void clear_frame_model();
      frame_crc     = mrc_pkg::CRC_INIT;
      frame_tail    = '0;
      frame_count   = '0;
      frame_overrun = 1'b0;
   endfunction

   // Fold one accepted word into the predictor; an end-of-frame word owes a verdict.
   function automatic void track_word(mrc_pkg::opcode_type op, logic [7:0] b);
      mrc_pkg::result_type verdict;
      if (op == mrc_pkg::OP_DATA) begin
         if (frame_count >= FRAME_CAP) begin
            frame_overrun = 1'b1;   // dropped byte, frame is marked overflowed
         end else begin
            // the byte leaving the two-byte hold-back joins the CRC
            if (frame_count >= 2) begin
               frame_crc = modbus_crc_byte(frame_crc, frame_tail[7:0]);
            end
            frame_tail  = {b, frame_tail[15:8]};
            frame_count = frame_count + 9'd1;
         end
      end else begin
         if (frame_overrun) begin
            verdict.frame_status = mrc_pkg::ST_OVER;
         end else if (frame_count < 2 || frame_count < {1'b0, min_len_reg}) begin
            verdict.frame_status = mrc_pkg::ST_SHORT;
         end else if (frame_tail == frame_crc) begin
            verdict.frame_status = mrc_pkg::ST_OK;
         end else begin
            verdict.frame_status = mrc_pkg::ST_CRC;
         end
         verdict.frame_length = frame_count;
         verdict.trailer_crc  = frame_tail;
         verdict.computed_crc = frame_crc;
         expected_frames.push_back(verdict);
         clear_frame_model();
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Clock.
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Response side: ready held high, dropped for bursts of random length.
   // Exactly one nonblocking write of ready per time step.
   // ---------------------------------------------------------------------------
   initial begin
      rsp_ch.ready = 1'b1;
      forever begin
         @(posedge clock);
         if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // Response checker: every accepted response is compared with the oldest verdict.
   // Outputs are read right after the edge, i.e. the values the edge saw.
   // ---------------------------------------------------------------------------
   task automatic report_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
         $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, seen);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      mrc_pkg::result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_frames.size() == 0) begin
            $display("%0t: response with none pending, expected nothing actual status %0d len %0d",
                     $time, rsp_ch.frame_status, rsp_ch.frame_length);
            mismatches++;
         end else begin
            want = expected_frames.pop_front();
            report_field("frame_status", want.frame_status, rsp_ch.frame_status);
            report_field("frame_length", want.frame_length, rsp_ch.frame_length);
            report_field("trailer_crc", want.trailer_crc, rsp_ch.trailer_crc);
            report_field("computed_crc", want.computed_crc, rsp_ch.computed_crc);
         end
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Request side.
   // ---------------------------------------------------------------------------

   // Send one word; returns right after the edge that accepted it. valid stays
   // high for a following word and is only lowered for a gap or a park.
   task automatic send_word(mrc_pkg::opcode_type op, logic [7:0] b);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.opcode  <= op;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      track_word(op, b);
      sent_words++;
   endtask

   // Drop valid and wait out every owed verdict plus the result pipeline.
   task automatic drain_frames();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_min_len(logic [7:0] v);
      drain_frames();
      csr_ch.valid            <= 1'b1;
      csr_ch.min_frame_length <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      min_len_reg = v;
   endtask

   // Fill frame_buf with n bytes: payload plus its CRC, low byte first.
   // Below two bytes there is no room for a CRC and the bytes are random.
   function automatic void build_frame(int unsigned n);
      logic [15:0] crc;
      logic [7:0]  b;
      frame_buf.delete();
      crc = mrc_pkg::CRC_INIT;
      if (n < 2) begin
         for (int unsigned i = 0; i < n; i++) frame_buf.push_back(8'($urandom));
      end else begin
         for (int unsigned i = 0; i < n - 2; i++) begin
            b = 8'($urandom);
            crc = modbus_crc_byte(crc, b);
            frame_buf.push_back(b);
         end
         frame_buf.push_back(crc[7:0]);
         frame_buf.push_back(crc[15:8]);
      end
   endfunction

   // Flip one random bit of one random byte.
   function automatic void corrupt_frame();
      int unsigned idx;
      if (frame_buf.size() != 0) begin
         idx = $urandom_range(0, frame_buf.size() - 1);
         frame_buf[idx] = frame_buf[idx] ^ (8'd1 << $urandom_range(0, 7));
      end
   endfunction

   task automatic send_frame();
      foreach (frame_buf[i]) send_word(mrc_pkg::OP_DATA, frame_buf[i]);
      send_word(mrc_pkg::OP_EOF, 8'($urandom));   // byte lane is don't-care on end of frame
   endtask

   // ---------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------

   // Reset minimum length (5): empty frame, one and two bytes, short good
   // frame, exact-minimum good frame and a broken CRC.
   task automatic test_short_and_crc();
      send_word(mrc_pkg::OP_EOF, 8'hFF);              // empty frame: short, length 0
      send_word(mrc_pkg::OP_DATA, 8'h00);             // one byte lands in the high half
      send_word(mrc_pkg::OP_EOF, 8'h00);
      send_word(mrc_pkg::OP_DATA, 8'hFF);
      send_word(mrc_pkg::OP_DATA, 8'hFF);
      send_word(mrc_pkg::OP_EOF, 8'h00);
      build_frame(4);                                 // valid CRC but under minimum
      send_frame();
      build_frame(5);                                 // shortest passing frame
      send_frame();
      build_frame(5);
      frame_buf[4] = frame_buf[4] ^ 8'h80;            // bad CRC high byte
      send_frame();
   endtask

   // Sweep the register through its low end and 7; frames land just
   // around each value.
   task automatic test_min_length();
      logic [7:0] settings[5] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd7};
      int unsigned lo;
      foreach (settings[s]) begin
         write_min_len(settings[s]);
         lo = (settings[s] == 0) ? 0 : settings[s] - 1;
         for (int unsigned n = lo; n <= settings[s] + 1; n++) begin
            build_frame(n);
            send_frame();
         end
      end
   endtask

   // Register at its top; frames at and past the buffer size; the frame after
   // must start clean.
   task automatic test_overflow();
      write_min_len(8'd255);
      build_frame(FRAME_CAP);           // fits exactly, above the minimum: ok
      send_frame();
      build_frame(FRAME_CAP + 1);       // one byte dropped: overflow
      send_frame();
      build_frame(6);                   // below the minimum: short
      send_frame();
   endtask

   // Mostly well-formed frames with random content, some broken, some noise,
   // a few long ones; register and idling change between phases.
   task automatic test_random_traffic();
      int unsigned stop_at;
      int unsigned pick;
      stop_at = sent_words + 70;
      while (sent_words < stop_at) begin
         pick = $urandom_range(0, 3);
         gap_pct   = (pick == 0) ? 0 : $urandom_range(5, 50);
         stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
         if ($urandom_range(0, 4) == 0) begin
            write_min_len(8'($urandom));
         end else begin
            write_min_len(8'($urandom_range(0, 8)));
         end
         repeat (4) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               build_frame($urandom_range(2, 14));
            end else if (pick < 75) begin
               build_frame($urandom_range(2, 14));
               corrupt_frame();
            end else if (pick < 92) begin
               build_frame($urandom_range(0, 6));   // noise / runt frames
            end else begin
               build_frame($urandom_range(15, 60));
            end
            send_frame();
         end
      end
   endtask

   // Closing stretch at full rate: no send gaps, no response stalls.
   task automatic test_full_rate();
      gap_pct   = 0;
      stall_pct = 0;
      write_min_len(8'd4);
      repeat (10) begin
         build_frame($urandom_range(0, 10));
         if ($urandom_range(0, 3) == 0) corrupt_frame();
         send_frame();
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------------
   initial begin
      reset                   = 1'b1;
      req_ch.valid            = 1'b0;
      req_ch.opcode           = mrc_pkg::OP_DATA;
      req_ch.rx_byte          = '0;
      csr_ch.valid            = 1'b0;
      csr_ch.min_frame_length = '0;
      mismatches   = 0;
      sent_words   = 0;
      gap_pct      = 0;
      stall_pct    = 0;
      min_len_reg  = mrc_pkg::MIN_LEN_RESET;
      clear_frame_model();

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_and_crc();
      gap_pct   = 20;
      stall_pct = 20;
      test_min_length();
      test_overflow();
      test_random_traffic();
      test_full_rate();

      drain_frames();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && expected_frames.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/mrc_pkg.sv
sv/mrc_channels.sv
sv/mrc_frame_core.sv
sv/modbus_rtu_response_checker.sv
sim/tb_top.sv
